// ----- src/nrd_pkg.sv -----
// Shared types and constants for the receive ring deframer.
package nrd_pkg;

   localparam logic [16:0] RING_BYTES  = 17'd32768;
   localparam logic [15:0] BAD_HEADER  = 16'hFFF0;
   localparam logic [15:0] PTR_BIAS    = 16'd16;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_PAD    = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0]  pbyte;
      logic        pvalid;
      logic        plast;
      logic        ptrv;
      logic [15:0] offset;
      logic        herr;
   } result_type;

endpackage

// ----- src/nrd_if.sv -----
// Stream interfaces for ring bytes in and deframed results out.
interface nrd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ring_byte;
   modport source (output valid, output ring_byte, input ready);
   modport sink (input valid, input ring_byte, output ready);
endinterface

interface nrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  payload_byte;
   logic        payload_valid;
   logic        payload_last;
   logic        pointer_valid;
   logic [15:0] read_pointer_report;
   logic        header_error;
   modport source (output valid, output payload_byte, output payload_valid,
                   output payload_last, output pointer_valid,
                   output read_pointer_report, output header_error, input ready);
   modport sink (input valid, input payload_byte, input payload_valid,
                 input payload_last, input pointer_valid,
                 input read_pointer_report, input header_error, output ready);
endinterface

// ----- src/nrd_front.sv -----
// Front end: header parse, frame walk, offset tracking, result classification.
module nrd_front #(
   parameter logic [16:0] RING_BYTES = nrd_pkg::RING_BYTES
) (
   input  logic               clock,
   input  logic               reset,
   nrd_req_if.sink            req_ch,
   input  logic               queue_full,
   output logic               push,
   output nrd_pkg::result_type push_data
);

   nrd_pkg::phase_type phase_ff, phase_in;
   logic [15:0] status_ff, status_in;
   logic [13:0] len_ff, len_in;
   logic [14:0] bif_ff, bif_in;
   logic [15:0] ro_ff, ro_in;

   logic        accept;
   logic [7:0]  b;
   logic [1:0]  pos;
   logic [1:0]  pad;
   logic [15:0] raw;
   logic        hdr_bad;
   logic [14:0] k;
   logic [14:0] bif_next;
   logic        pay_ok;
   logic        pay_last;
   logic        body_done;
   logic        pad_done;
   logic        frame_end;
   logic [16:0] off_sum;
   logic [16:0] off_round;
   logic [15:0] new_off;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid & req_ch.ready;
   assign b            = req_ch.ring_byte;
   assign pos          = bif_ff[1:0];
   assign raw          = {b, len_ff[7:0]};
   assign hdr_bad      = (raw == nrd_pkg::BAD_HEADER) || (raw[13:0] == 14'd0);
   assign k            = bif_ff - 15'd4;
   assign bif_next     = bif_ff + 15'd1;
   assign pad          = 2'd0 - 2'(ro_ff[1:0] + len_ff[1:0]);
   assign pay_ok       = status_ff[0] && (len_ff > 14'd4) &&
                         (k < {1'b0, 14'(len_ff - 14'd4)});
   assign pay_last     = (k == {1'b0, 14'(len_ff - 14'd5)});
   assign body_done    = ({1'b0, bif_ff} >= ({2'b00, len_ff} + 16'd3));
   assign pad_done     = ({1'b0, bif_next} >= ({2'b00, len_ff} + 16'd4 + {14'd0, pad}));
   assign off_sum      = {1'b0, ro_ff} + {3'b000, len_ff} + 17'd7;
   assign off_round    = {off_sum[16:2], 2'b00};
   assign new_off      = (off_round >= RING_BYTES) ?
                         16'(off_round - RING_BYTES) : off_round[15:0];
   assign frame_end    = accept &&
                         (((phase_ff == nrd_pkg::PH_BODY) && body_done && (pad == 2'd0)) ||
                          ((phase_ff == nrd_pkg::PH_PAD) && pad_done));

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            nrd_pkg::PH_BODY: begin
               if (body_done) begin
                  phase_in = (pad == 2'd0) ? nrd_pkg::PH_HEADER : nrd_pkg::PH_PAD;
               end
            end
            nrd_pkg::PH_PAD: begin
               if (pad_done) begin
                  phase_in = nrd_pkg::PH_HEADER;
               end
            end
            default: begin
               phase_in = ((pos == 2'd3) && !hdr_bad) ? nrd_pkg::PH_BODY
                                                      : nrd_pkg::PH_HEADER;
            end
         endcase
      end
   end

   always_comb begin
      status_in = status_ff;
      len_in    = len_ff;
      bif_in    = bif_ff;
      ro_in     = ro_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         case (phase_ff)
            nrd_pkg::PH_BODY: begin
               bif_in = bif_next;
               if (pay_ok) begin
                  push             = 1'b1;
                  push_data.pbyte  = b;
                  push_data.pvalid = 1'b1;
                  push_data.plast  = pay_last;
               end
            end
            nrd_pkg::PH_PAD: begin
               bif_in = bif_next;
            end
            default: begin
               case (pos)
                  2'd0: begin
                     status_in = {8'h00, b};
                     bif_in    = 15'd1;
                  end
                  2'd1: begin
                     status_in = {b, status_ff[7:0]};
                     bif_in    = 15'd2;
                  end
                  2'd2: begin
                     len_in = {6'd0, b};
                     bif_in = 15'd3;
                  end
                  default: begin
                     len_in = raw[13:0];
                     bif_in = hdr_bad ? 15'd0 : 15'd4;
                     if (hdr_bad) begin
                        push           = 1'b1;
                        push_data.herr = 1'b1;
                     end
                  end
               endcase
            end
         endcase
         if (frame_end) begin
            ro_in            = new_off;
            bif_in           = 15'd0;
            push             = 1'b1;
            push_data.ptrv   = 1'b1;
            push_data.offset = new_off;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= nrd_pkg::PH_HEADER;
         status_ff <= '0;
         len_ff    <= '0;
         bif_ff    <= '0;
         ro_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         len_ff    <= len_in;
         bif_ff    <= bif_in;
         ro_ff     <= ro_in;
      end
   end

endmodule

// ----- src/nrd_queue.sv -----
// Two-entry result queue between front end and output stage.
module nrd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  nrd_pkg::result_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output nrd_pkg::result_type pop_data
);

   localparam int unsigned PtrBits = $clog2(nrd_pkg::QUEUE_DEPTH);
   localparam int unsigned CntBits = $clog2(nrd_pkg::QUEUE_DEPTH + 1);

   nrd_pkg::result_type entry_ff [nrd_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == CntBits'(nrd_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(nrd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_ff + PtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(nrd_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_ff + PtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/nrd_back.sv -----
// Output stage: formats queued results and holds them until transfer.
module nrd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  nrd_pkg::result_type queue_data,
   output logic                pop,
   nrd_rsp_if.source           rsp_ch
);

   logic        valid_ff, valid_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic        pvalid_ff, pvalid_in;
   logic        plast_ff, plast_in;
   logic        ptrv_ff, ptrv_in;
   logic [15:0] ptr_ff, ptr_in;
   logic        herr_ff, herr_in;

   assign pop = !queue_empty && (!valid_ff || rsp_ch.ready);

   always_comb begin
      valid_in  = valid_ff;
      pbyte_in  = pbyte_ff;
      pvalid_in = pvalid_ff;
      plast_in  = plast_ff;
      ptrv_in   = ptrv_ff;
      ptr_in    = ptr_ff;
      herr_in   = herr_ff;
      if (pop) begin
         valid_in  = 1'b1;
         pbyte_in  = queue_data.pbyte;
         pvalid_in = queue_data.pvalid;
         plast_in  = queue_data.plast;
         ptrv_in   = queue_data.ptrv;
         ptr_in    = queue_data.ptrv ? (queue_data.offset - nrd_pkg::PTR_BIAS) : 16'd0;
         herr_in   = queue_data.herr;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pbyte_ff  <= pbyte_in;
      pvalid_ff <= pvalid_in;
      plast_ff  <= plast_in;
      ptrv_ff   <= ptrv_in;
      ptr_ff    <= ptr_in;
      herr_ff   <= herr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_ch.valid               = valid_ff;
   assign rsp_ch.payload_byte        = pbyte_ff;
   assign rsp_ch.payload_valid       = pvalid_ff;
   assign rsp_ch.payload_last        = plast_ff;
   assign rsp_ch.pointer_valid       = ptrv_ff;
   assign rsp_ch.read_pointer_report = ptr_ff;
   assign rsp_ch.header_error        = herr_ff;

endmodule

// ----- src/nic_rx_ring_deframer_core.sv -----
// Receive ring deframer top level: front end, result queue, output stage.
// A ring byte's result passes through a queue entry and the output register before it can transfer.
// Throughput: one ring byte per cycle while the result queue is not full.
// The two-entry queue and output register let input continue while a result waits;
// input stalls only while both queue entries hold results.
// Synchronous active-high reset: expect a header at ring offset 0, queue and output empty.
module nic_rx_ring_deframer_core #(
   parameter logic [16:0] RING_BYTES = nrd_pkg::RING_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   nrd_req_if.sink   req_ch,
   nrd_rsp_if.source rsp_ch
);

   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_empty;
   nrd_pkg::result_type push_data;
   nrd_pkg::result_type pop_data;

   nrd_front #(
      .RING_BYTES (RING_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   nrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .pop_data  (pop_data)
   );

   nrd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp_ch      (rsp_ch)
   );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the receive ring deframer: byte stream in, results checked.
`timescale 1ns / 1ps

module tb_top;

   localparam int LATENCY         = 2;
   localparam int WATCHDOG_CYCLES = 5000;
   localparam int HOLD_CYCLES     = 200;
   localparam int PHASE_BYTES     = 180;

   localparam nrd_pkg::result_type NO_RESULT  = '0;
   localparam nrd_pkg::result_type HDR_REJECT = '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b1};

   typedef struct {
      logic [7:0]          b;
      bit                  fixed;
      bit                  has;
      nrd_pkg::result_type r;
   } stim_row_type;

   logic clock;
   logic reset;

   nrd_req_if req_if ();
   nrd_rsp_if rsp_if ();

   nic_rx_ring_deframer_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // deframer state as predicted
   nrd_pkg::phase_type rx_phase;
   logic [15:0]        rx_status;
   logic [13:0]        rx_len;
   logic [14:0]        rx_pos;
   logic [15:0]        rx_ring_off;

   nrd_pkg::result_type pending_results[$];
   stim_row_type        stim_rows[$];

   int errors       = 0;
   int bytes_taken  = 0;
   int payload_cnt  = 0;
   int frames_done  = 0;
   int reject_cnt   = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int hold_req     = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   int send_idle[4]  = '{0, 47, 0, 27};
   int recv_stall[4] = '{0, 0, 47, 27};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit deframe_step(input logic [7:0] b, output nrd_pkg::result_type r);
      int unsigned u, k, n, pad, fl, cnt;
      logic [15:0] raw;
      bit fend;
      r    = '0;
      fend = 1'b0;
      fl   = rx_len;
      u    = rx_ring_off + fl + 4;
      pad  = ((u + 3) & ~32'd3) - u;
      case (rx_phase)
         nrd_pkg::PH_BODY: begin
            cnt = rx_pos;
            k   = cnt - 4;
            if (rx_status[0] && fl > 4 && k < fl - 4) begin
               r.pbyte  = b;
               r.pvalid = 1'b1;
               r.plast  = (k == fl - 5);
            end
            if (cnt >= fl + 3) begin
               if (pad == 0) fend = 1'b1;
               else rx_phase = nrd_pkg::PH_PAD;
            end
            rx_pos = rx_pos + 15'd1;
         end
         nrd_pkg::PH_PAD: begin
            rx_pos = rx_pos + 15'd1;
            cnt    = rx_pos;
            if (cnt >= fl + 4 + pad) fend = 1'b1;
         end
         default: begin
            case (rx_pos[1:0])
               2'd0: rx_status = {8'h00, b};
               2'd1: rx_status = {b, rx_status[7:0]};
               2'd2: rx_len = {6'd0, b};
               default: begin
                  raw    = {b, rx_len[7:0]};
                  rx_len = raw[13:0];
                  if (raw == nrd_pkg::BAD_HEADER || raw[13:0] == 14'd0) begin
                     r.herr   = 1'b1;
                     rx_phase = nrd_pkg::PH_HEADER;
                     rx_pos   = '0;
                  end else begin
                     rx_phase = nrd_pkg::PH_BODY;
                     rx_pos   = 15'd4;
                  end
               end
            endcase
            if (rx_pos[1:0] != 2'd3 && rx_phase != nrd_pkg::PH_BODY && !r.herr) begin
               rx_phase = nrd_pkg::PH_HEADER;
            end
            if (rx_phase == nrd_pkg::PH_HEADER && !r.herr && rx_pos < 15'd3 && rx_pos != 15'd4)
               rx_pos = rx_pos + 15'd1;
            else if (rx_phase == nrd_pkg::PH_HEADER && !r.herr && rx_pos == 15'd3)
               rx_pos = rx_pos;
         end
      endcase
      if (fend) begin
         n = (u + 3) & ~32'd3;
         if (n >= nrd_pkg::RING_BYTES) n = n - nrd_pkg::RING_BYTES;
         rx_ring_off = n[15:0];
         r.ptrv      = 1'b1;
         r.offset    = rx_ring_off - nrd_pkg::PTR_BIAS;
         rx_phase    = nrd_pkg::PH_HEADER;
         rx_pos      = '0;
      end
      return r.pvalid | r.ptrv | r.herr;
   endfunction

   task automatic add_row(input logic [7:0] b, input bit fixed, input bit has,
                          input nrd_pkg::result_type r);
      stim_row_type row;
      row.b     = b;
      row.fixed = fixed;
      row.has   = has;
      row.r     = r;
      stim_rows.push_back(row);
   endtask

   task automatic send_byte(input logic [7:0] b, input bit fixed, input bit fixed_has,
                            input nrd_pkg::result_type fixed_r);
      nrd_pkg::result_type r;
      bit has;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.ring_byte <= b;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      has = deframe_step(b, r);
      bytes_taken++;
      if (has) begin
         if (r.pvalid) payload_cnt++;
         if (r.ptrv) frames_done++;
         if (r.herr) reject_cnt++;
      end
      if (fixed) begin
         if (fixed_has) pending_results.push_back(fixed_r);
      end else if (has) begin
         pending_results.push_back(r);
      end
   endtask

   task automatic send_frame(input logic [15:0] status, input logic [15:0] len_word);
      int unsigned len, total;
      len = len_word[13:0];
      send_byte(status[7:0], 1'b0, 1'b0, NO_RESULT);
      send_byte(status[15:8], 1'b0, 1'b0, NO_RESULT);
      send_byte(len_word[7:0], 1'b0, 1'b0, NO_RESULT);
      send_byte(len_word[15:8], 1'b0, 1'b0, NO_RESULT);
      if (len_word != nrd_pkg::BAD_HEADER && len != 0) begin
         total = len + ((4 - len % 4) % 4);
         repeat (total) send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
      end
   endtask

   task automatic rand_frame();
      int sel;
      logic [15:0] status, len_word;
      sel       = $urandom_range(0, 99);
      status    = 16'($urandom);
      status[0] = ($urandom_range(0, 99) < 80);
      if (sel < 5) len_word = {2'($urandom), 14'd0};
      else if (sel < 10) len_word = nrd_pkg::BAD_HEADER;
      else if (sel < 25) len_word = {2'($urandom), 14'($urandom_range(1, 4))};
      else len_word = {2'($urandom), 14'($urandom_range(5, 48))};
      send_frame(status, len_word);
   endtask

   // result checker and receiver stall control
   always @(posedge clock) begin : rsp_check
      nrd_pkg::result_type e;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer");
               errors++;
            end else begin
               e = pending_results.pop_front();
               if (rsp_if.payload_byte !== e.pbyte) begin
                  $error("payload_byte: expected %h, got %h", e.pbyte, rsp_if.payload_byte);
                  errors++;
               end
               if (rsp_if.payload_valid !== e.pvalid) begin
                  $error("payload_valid: expected %b, got %b", e.pvalid, rsp_if.payload_valid);
                  errors++;
               end
               if (rsp_if.payload_last !== e.plast) begin
                  $error("payload_last: expected %b, got %b", e.plast, rsp_if.payload_last);
                  errors++;
               end
               if (rsp_if.pointer_valid !== e.ptrv) begin
                  $error("pointer_valid: expected %b, got %b", e.ptrv, rsp_if.pointer_valid);
                  errors++;
               end
               if (rsp_if.read_pointer_report !== e.offset) begin
                  $error("read_pointer_report: expected %h, got %h", e.offset,
                         rsp_if.read_pointer_report);
                  errors++;
               end
               if (rsp_if.header_error !== e.herr) begin
                  $error("header_error: expected %b, got %b", e.herr, rsp_if.header_error);
                  errors++;
               end
            end
         end
         if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.ring_byte = 8'h00;
      rsp_if.ready     = 1'b0;
      rx_phase         = nrd_pkg::PH_HEADER;
      rx_status        = '0;
      rx_len           = '0;
      rx_pos           = '0;
      rx_ring_off      = '0;

      // zero length header, then a header with the 0xFFF0 length word
      add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b1, HDR_REJECT);
      add_row(8'hFF, 1'b1, 1'b0, NO_RESULT);
      add_row(8'hFF, 1'b1, 1'b0, NO_RESULT);
      add_row(8'hF0, 1'b1, 1'b0, NO_RESULT);
      add_row(8'hFF, 1'b1, 1'b1, HDR_REJECT);
      // good frame, length 6: two payload bytes, CRC, two pad bytes
      add_row(8'h01, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h06, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b1,
              nrd_pkg::result_type'{8'h00, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0});
      add_row(8'hFF, 1'b1, 1'b1,
              nrd_pkg::result_type'{8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000, 1'b0});
      add_row(8'hAA, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h55, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h12, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h34, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b0, NO_RESULT);
      add_row(8'h00, 1'b1, 1'b1,
              nrd_pkg::result_type'{8'h00, 1'b0, 1'b0, 1'b1, 16'hFFFC, 1'b0});
      // bad short frame, masked length bits set, one pad byte
      add_row(8'hFE, 1'b0, 1'b0, NO_RESULT);
      add_row(8'h80, 1'b0, 1'b0, NO_RESULT);
      add_row(8'h03, 1'b0, 1'b0, NO_RESULT);
      add_row(8'hC0, 1'b0, 1'b0, NO_RESULT);
      add_row(8'h7F, 1'b0, 1'b0, NO_RESULT);
      add_row(8'h80, 1'b0, 1'b0, NO_RESULT);
      add_row(8'h01, 1'b0, 1'b0, NO_RESULT);
      add_row(8'h5A, 1'b0, 1'b0, NO_RESULT);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i])
         send_byte(stim_rows[i].b, stim_rows[i].fixed, stim_rows[i].has, stim_rows[i].r);

      for (int p = 0; p < 4; p++) begin
         int start_bytes;
         idle_pct    = send_idle[p];
         stall_pct   = recv_stall[p];
         start_bytes = bytes_taken;
         if (p == 0) begin
            // receiver holds off while a good frame streams in
            hold_req = HOLD_CYCLES;
            send_frame(16'h0001, 16'd40);
            start_bytes = bytes_taken;
         end
         while (bytes_taken - start_bytes < PHASE_BYTES) rand_frame();
      end

      req_if.valid <= 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      $display("Ran %0d ring bytes under four idle/stall mixes incl. a long receiver hold-off",
               bytes_taken);
      $display("Checked %0d payload bytes, %0d frame ends, %0d bad headers",
               payload_cnt, frames_done, reject_cnt);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
